>>> src/blocked_slot_allocator_defines.svh
// Assertion macros shared by the slot allocator RTL.
`ifndef BLOCKED_SLOT_ALLOCATOR_DEFINES_SVH
`define BLOCKED_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define BSA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must never hold.
`define BSA_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

>>> src/bsa_pkg.sv
// Package: types and constants of the blocked slot allocator.
`default_nettype none

package bsa_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int SLOTS      = 64;

  localparam int BLK_W   = 4;
  localparam int SLOT_W  = 6;
  localparam int FILL_W  = 7;
  localparam int BC_W    = 5;
  localparam int CNT_W   = 11;
  localparam int ADDR_W  = BLK_W + SLOT_W;
  localparam int STACK_DEPTH = MAX_BLOCKS * SLOTS;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_BLOCK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT     = 1'd1;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_FULL     = 2'd1,
    ERR_BAD_FREE = 2'd2
  } err_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [BLK_W-1:0]  freed_block;
    logic [SLOT_W-1:0] freed_slot;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [1:0]        error_code;
    logic [BLK_W-1:0]  given_block;
    logic [SLOT_W-1:0] given_slot;
    logic [CNT_W-1:0]  in_use_count;
  } out_t;

  // Stack memory access for one operation.
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] wdata;
  } mem_req_t;

  // Result of one operation, before the popped slot is known.
  typedef struct packed {
    logic              ok;
    err_e              error_code;
    logic [BLK_W-1:0]  given_block;
    logic [SLOT_W-1:0] slot_pos;
    logic              use_ident;
    logic              give_slot;
    logic [CNT_W-1:0]  in_use_count;
  } res_t;

endpackage

`default_nettype wire

>>> src/bsa_stack_ram.sv
// Free-slot stack memory: one write or one read per cycle, registered read data.
`default_nettype none

module bsa_stack_ram import bsa_pkg::*; (
  input  logic              clk,
  input  mem_req_t          req,
  output logic [SLOT_W-1:0] rdata
);

  logic [SLOT_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

>>> src/bsa_fill_ctrl.sv
// Fill counts, high-water marks, block search and per-operation decisions.
`default_nettype none
`include "blocked_slot_allocator_defines.svh"

module bsa_fill_ctrl import bsa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  in_t               op,
  input  logic [FILL_W-1:0] spb_eff,
  input  logic [BC_W-1:0]   bc_eff,
  output mem_req_t          mem_req,
  output res_t              res
);

  logic [FILL_W-1:0] fill [MAX_BLOCKS];
  // Highest fill seen since clear; stack entries at or above it still hold identity.
  logic [FILL_W-1:0] hwm  [MAX_BLOCKS];
  logic [CNT_W-1:0]  total;

  logic [MAX_BLOCKS-1:0] nonfull;
  logic                  found;
  logic [BLK_W-1:0]      hit_blk;
  logic [FILL_W-1:0]     alloc_pos;
  logic [FILL_W-1:0]     free_fill;
  logic [FILL_W-1:0]     free_pos;
  logic                  free_bad;

  logic              upd;
  logic [BLK_W-1:0]  upd_blk;
  logic [FILL_W-1:0] upd_fill;
  logic              hwm_raise;
  logic              clr;
  logic [CNT_W-1:0]  total_next;
  mem_req_t          req;

  always_comb begin
    for (int b = 0; b < MAX_BLOCKS; b++) begin
      nonfull[b] = (BC_W'(b) < bc_eff) && (fill[b] < spb_eff);
    end
    found   = |nonfull;
    hit_blk = '0;
    for (int b = MAX_BLOCKS - 1; b >= 0; b--) begin
      if (nonfull[b]) begin
        hit_blk = BLK_W'(b);
      end
    end
  end

  assign alloc_pos = fill[hit_blk];
  assign free_fill = fill[op.freed_block];
  assign free_pos  = free_fill - 1'b1;
  assign free_bad  = ({1'b0, op.freed_block} >= bc_eff)
                  || ({1'b0, op.freed_slot} >= spb_eff)
                  || (free_fill == '0);

  always_comb begin
    res             = '0;
    res.error_code  = ERR_NONE;
    req             = '0;
    upd             = 1'b0;
    upd_blk         = '0;
    upd_fill        = '0;
    hwm_raise       = 1'b0;
    clr             = 1'b0;
    total_next      = total;
    unique case (mode_e'(op.mode))
      MODE_ALLOC: begin
        if (found) begin
          res.ok          = 1'b1;
          res.given_block = hit_blk;
          res.slot_pos    = alloc_pos[SLOT_W-1:0];
          res.use_ident   = alloc_pos >= hwm[hit_blk];
          res.give_slot   = 1'b1;
          req.rd_en       = 1'b1;
          req.addr        = {hit_blk, alloc_pos[SLOT_W-1:0]};
          upd             = 1'b1;
          upd_blk         = hit_blk;
          upd_fill        = alloc_pos + 1'b1;
          hwm_raise       = res.use_ident;
          total_next      = total + 1'b1;
        end else begin
          res.error_code = ERR_FULL;
        end
      end
      MODE_FREE: begin
        if (free_bad) begin
          res.error_code = ERR_BAD_FREE;
        end else begin
          res.ok     = 1'b1;
          req.wr_en  = 1'b1;
          req.addr   = {op.freed_block, free_pos[SLOT_W-1:0]};
          req.wdata  = op.freed_slot;
          upd        = 1'b1;
          upd_blk    = op.freed_block;
          upd_fill   = free_pos;
          total_next = (total != '0) ? total - 1'b1 : total;
        end
      end
      MODE_CLEAR: begin
        res.ok     = 1'b1;
        clr        = 1'b1;
        total_next = '0;
      end
      MODE_NOP: begin
      end
      default: begin
      end
    endcase
    res.in_use_count = total_next;
    mem_req          = req;
    mem_req.rd_en    = req.rd_en & go;
    mem_req.wr_en    = req.wr_en & go;
  end

  always_ff @(posedge clk) begin
    if (rst || (go && clr)) begin
      for (int b = 0; b < MAX_BLOCKS; b++) begin
        fill[b] <= '0;
        hwm[b]  <= '0;
      end
      total <= '0;
    end else if (go) begin
      if (upd) begin
        fill[upd_blk] <= upd_fill;
      end
      if (hwm_raise) begin
        hwm[upd_blk] <= upd_fill;
      end
      total <= total_next;
    end
  end

  `BSA_NEVER(a_rd_wr_excl, clk, rst, mem_req.rd_en && mem_req.wr_en, "stack read and write together")
  `BSA_ASSERT_NEXT(a_alloc_count, clk, rst, go && mem_req.rd_en, total == $past(total) + 1'b1, "allocate did not bump count")
  `BSA_ASSERT_NOW(a_ident_at_mark, clk, rst, mem_req.rd_en && res.use_ident, fill[hit_blk] == hwm[hit_blk], "fill passed its high-water mark")

endmodule

`default_nettype wire

>>> src/blocked_slot_allocator.sv
// Top level of the blocked slot allocator: config registers, result stages, stack RAM.
//
//   channel  direction  handshake            beat
//   in       in         in_valid / in_stall   in_data  (mode, freed_block, freed_slot)
//   out      out        out_valid / out_stall out_data (ok, error_code, handle, count)
//   cfg      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// An input beat is decided in its accept cycle: block search over the fill counts,
// fill and count update, and at most one stack RAM access (pop read or push write).
// The result waits in pend_res for the RAM read data, then is registered into out_data.
// Sustained rate is one beat per cycle while out_stall is low; the single-port stack RAM sets that limit.
// Reset (synchronous, rst) zeroes fill counts, high-water marks and the count;
// no clearing pass is needed, so items are taken from the first cycle after reset.
// in_stall rises only when a result is pending and the out register is held by out_stall.
`default_nettype none
`include "blocked_slot_allocator_defines.svh"

module blocked_slot_allocator import bsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Raw register values; saturated below before use.
  logic [FILL_W-1:0] slots_per_block;
  logic [BC_W-1:0]   block_count;
  logic [FILL_W-1:0] spb_eff;
  logic [BC_W-1:0]   bc_eff;

  logic              in_accept;
  logic              pend;       // a decided beat waits for the out register
  res_t              pend_res;
  logic              move;       // pending beat goes to out this edge
  res_t              res;
  mem_req_t          mem_req;
  logic [SLOT_W-1:0] ram_rdata;
  logic [SLOT_W-1:0] slot_val;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_per_block <= FILL_W'(SLOTS);
      block_count     <= BC_W'(MAX_BLOCKS);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SLOTS_PER_BLOCK) begin
        slots_per_block <= cfg_data[FILL_W-1:0];
      end
      if (cfg_index == CFG_BLOCK_COUNT) begin
        block_count <= cfg_data[BC_W-1:0];
      end
    end
  end

  // Zero means one; anything past the pool size means the pool size.
  assign spb_eff = (slots_per_block == '0) ? FILL_W'(1)
                 : (slots_per_block > FILL_W'(SLOTS)) ? FILL_W'(SLOTS) : slots_per_block;
  assign bc_eff  = (block_count == '0) ? BC_W'(1)
                 : (block_count > BC_W'(MAX_BLOCKS)) ? BC_W'(MAX_BLOCKS) : block_count;

  assign move      = pend && (!out_valid || !out_stall);
  assign in_stall  = pend && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  bsa_fill_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .go      (in_accept),
    .op      (in_data),
    .spb_eff (spb_eff),
    .bc_eff  (bc_eff),
    .mem_req (mem_req),
    .res     (res)
  );

  bsa_stack_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (ram_rdata)
  );

  // Untouched stack entries read as their own position.
  assign slot_val = !pend_res.give_slot ? '0
                  : pend_res.use_ident ? pend_res.slot_pos : ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        pend <= 1'b1;
      end else if (move) begin
        pend <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_res <= res;
    end
    if (move) begin
      out_data.ok           <= pend_res.ok;
      out_data.error_code   <= pend_res.error_code;
      out_data.given_block  <= pend_res.given_block;
      out_data.given_slot   <= slot_val;
      out_data.in_use_count <= pend_res.in_use_count;
    end
  end

  `BSA_ASSERT_NEXT(a_accept_pends, clk, rst, in_accept, pend, "accepted beat not pending")
  `BSA_ASSERT_NOW(a_ok_no_err, clk, rst, out_valid && out_data.ok, out_data.error_code == ERR_NONE, "success with error code")
  `BSA_ASSERT_NOW(a_fail_no_handle, clk, rst, out_valid && !out_data.ok, out_data.given_slot == '0 && out_data.given_block == '0, "handle on failed beat")

endmodule

`default_nettype wire

>>> tb/blocked_slot_allocator_tb.sv
// Self-checking testbench for the blocked slot allocator: directed and random beats.
module blocked_slot_allocator_tb import bsa_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Slowest legal run is well under 1 ms; this allows for several times that.
  localparam longint RUN_LIMIT_NS = 10_000_000;

  typedef struct packed {
    logic [BLK_W-1:0]  blk;
    logic [SLOT_W-1:0] slot;
  } handle_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  blocked_slot_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Shadow of the pool: per-block fill counts, per-block LIFO of free slot numbers,
  // total in use, and the raw register values as written (saturated when used).
  logic [FILL_W-1:0] blk_fill [MAX_BLOCKS];
  logic [SLOT_W-1:0] free_slots [MAX_BLOCKS][SLOTS];
  logic [CNT_W-1:0]  slots_taken;
  logic [FILL_W-1:0] spb_reg = 7'd64;
  logic [BC_W-1:0]   bc_reg = 5'd16;

  out_t    expected_q[$];   // results still owed by the block, oldest first
  handle_t held_q[$];       // handles handed out and not yet returned by the stimulus

  // Zero gaps on both sides while set.
  bit no_gaps = 1'b0;
  int out_hold = 0;

  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int n_alloc_ok = 0;
  int n_full = 0;
  int n_bad_free = 0;
  int n_free_ok = 0;

  function automatic int used_spb();
    int s;
    s = spb_reg;
    if (s < 1) s = 1;
    if (s > SLOTS) s = SLOTS;
    return s;
  endfunction

  function automatic int used_bc();
    int b;
    b = bc_reg;
    if (b < 1) b = 1;
    if (b > MAX_BLOCKS) b = MAX_BLOCKS;
    return b;
  endfunction

  // Every stack back to identity order, nothing in use.
  function automatic void refill_pool();
    for (int b = 0; b < MAX_BLOCKS; b++) begin
      blk_fill[b] = '0;
      for (int j = 0; j < SLOTS; j++) free_slots[b][j] = SLOT_W'(j);
    end
    slots_taken = '0;
  endfunction

  // Expected result of one operation; updates the shadow pool.
  function automatic out_t apply_op(in_t op);
    out_t res;
    int   spb;
    int   bc;
    int   hit;
    int   pos;
    res = '0;
    spb = used_spb();
    bc  = used_bc();
    hit = -1;
    case (op.mode)
      MODE_ALLOC: begin
        // first block in order that is not full; fill at or above spb counts as full
        for (int b = 0; b < bc; b++) begin
          if (blk_fill[b] < spb) begin
            hit = b;
            break;
          end
        end
        if (hit >= 0) begin
          res.ok          = 1'b1;
          res.given_block = BLK_W'(hit);
          res.given_slot  = free_slots[hit][blk_fill[hit]];
          blk_fill[hit]   = blk_fill[hit] + 1'b1;
          slots_taken     = slots_taken + 1'b1;
        end else begin
          res.error_code = ERR_FULL;
        end
      end
      MODE_FREE: begin
        if (op.freed_block >= bc || op.freed_slot >= spb || blk_fill[op.freed_block] == 0) begin
          res.error_code = ERR_BAD_FREE;
        end else begin
          // push back on top of the block's stack; double frees go through unchecked
          pos = blk_fill[op.freed_block] - 1;
          free_slots[op.freed_block][pos] = op.freed_slot;
          blk_fill[op.freed_block] = FILL_W'(pos);
          if (slots_taken != 0) slots_taken = slots_taken - 1'b1;
          res.ok = 1'b1;
        end
      end
      MODE_CLEAR: begin
        refill_pool();
        res.ok = 1'b1;
      end
      default: ;  // unused mode: no change, ok low, no error
    endcase
    res.in_use_count = slots_taken;
    return res;
  endfunction

  function automatic in_t make_op(mode_e m, int blk, int slot);
    in_t op;
    op.mode        = m;
    op.freed_block = BLK_W'(blk);
    op.freed_slot  = SLOT_W'(slot);
    return op;
  endfunction

  // Sends one input beat after a random gap and books its expected result.
  // Valid stays high on return so back-to-back beats need no second assignment.
  task automatic send_item(in_t op);
    int   gap;
    out_t want;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = apply_op(op);
    expected_q.push_back(want);
    items_sent++;
    case (op.mode)
      MODE_ALLOC: begin
        if (want.ok) begin
          n_alloc_ok++;
          held_q.push_back('{blk: want.given_block, slot: want.given_slot});
        end else begin
          n_full++;
        end
      end
      MODE_FREE: begin
        if (want.ok) n_free_ok++;
        else n_bad_free++;
      end
      MODE_CLEAR: held_q.delete();
      default: ;
    endcase
  endtask

  // Stop sending and wait for every owed result, then idle for slack.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write; only called with the block drained.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_SLOTS_PER_BLOCK) spb_reg = val;
    else bc_reg = val[BC_W-1:0];
    reg_writes++;
    @(posedge clk);
  endtask

  // Output side: compare each accepted result beat, then draw the stall before the next.
  always @(posedge clk) begin : out_side
    out_t want;
    int   draw;
    if (rst) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (out_data.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, out_data.ok);
            mismatches++;
          end
          if (out_data.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, out_data.error_code);
            mismatches++;
          end
          if (out_data.given_block !== want.given_block) begin
            $error("given_block: expected %0d, got %0d", want.given_block, out_data.given_block);
            mismatches++;
          end
          if (out_data.given_slot !== want.given_slot) begin
            $error("given_slot: expected %0d, got %0d", want.given_slot, out_data.given_slot);
            mismatches++;
          end
          if (out_data.in_use_count !== want.in_use_count) begin
            $error("in_use_count: expected %0d, got %0d", want.in_use_count,
                   out_data.in_use_count);
            mismatches++;
          end
        end
        draw = no_gaps ? 0 : $urandom_range(0, 10);
        out_hold  <= draw;
        out_stall <= (draw != 0);
      end else if (out_hold > 1) begin
        out_hold <= out_hold - 1;
      end else begin
        out_hold  <= 0;
        out_stall <= 1'b0;
      end
    end
  end

  // Reset values: 64 slots, 16 blocks. LIFO reuse of a freed slot, free to an
  // empty block, unused mode, clear.
  task automatic test_defaults();
    send_item(make_op(MODE_ALLOC, 0, 0));
    send_item(make_op(MODE_ALLOC, 3, 9));
    send_item(make_op(MODE_FREE, 0, 0));
    send_item(make_op(MODE_ALLOC, 0, 0));
    send_item(make_op(MODE_FREE, 7, 5));
    send_item(make_op(MODE_NOP, 15, 63));
    send_item(make_op(MODE_CLEAR, 0, 0));
    drain();
  endtask

  // One slot in one block: pool full, free to a block past the count, free of a slot
  // past the size, free to an empty block; then zero in both registers saturates up.
  task automatic test_single_slot_pool();
    write_reg(CFG_SLOTS_PER_BLOCK, 7'd1);
    write_reg(CFG_BLOCK_COUNT, 7'd1);
    send_item(make_op(MODE_ALLOC, 0, 0));
    send_item(make_op(MODE_ALLOC, 0, 0));
    send_item(make_op(MODE_FREE, 1, 0));
    send_item(make_op(MODE_FREE, 0, 1));
    send_item(make_op(MODE_FREE, 0, 0));
    send_item(make_op(MODE_FREE, 0, 0));
    drain();
    write_reg(CFG_SLOTS_PER_BLOCK, 7'd0);
    write_reg(CFG_BLOCK_COUNT, 7'd0);
    send_item(make_op(MODE_ALLOC, 0, 0));
    send_item(make_op(MODE_ALLOC, 0, 0));
    drain();
  endtask

  // Small pool filled up, double free, then register changes with slots held:
  // shrinking leaves a block filled past the new size counting as full, oversized values saturate.
  task automatic test_register_change();
    write_reg(CFG_SLOTS_PER_BLOCK, 7'd2);
    write_reg(CFG_BLOCK_COUNT, 7'd2);
    send_item(make_op(MODE_CLEAR, 0, 0));
    repeat (4) send_item(make_op(MODE_ALLOC, 0, 0));
    send_item(make_op(MODE_ALLOC, 0, 0));
    send_item(make_op(MODE_FREE, 1, 1));
    send_item(make_op(MODE_FREE, 1, 1));
    send_item(make_op(MODE_FREE, 1, 0));
    drain();
    write_reg(CFG_SLOTS_PER_BLOCK, 7'd1);
    send_item(make_op(MODE_ALLOC, 0, 0));
    drain();
    write_reg(CFG_SLOTS_PER_BLOCK, 7'd127);
    write_reg(CFG_BLOCK_COUNT, 7'h7F);
    send_item(make_op(MODE_ALLOC, 0, 0));
    send_item(make_op(MODE_FREE, 15, 63));
    drain();
  endtask

  // Random phases, each under a fresh register setting. Most frees return handles
  // that were really handed out, so blocks fill, drain and refill in LIFO order;
  // the rest is noise: frees of random handles, clears and the unused mode.
  task automatic test_random();
    int      pick;
    int      idx;
    handle_t h;
    logic [CFG_DATA_W-1:0] val;
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case ($urandom_range(0, 9))
        0:       val = 7'd1;
        1:       val = 7'd0;
        2:       val = 7'd127;
        3:       val = 7'd64;
        4, 5, 6: val = CFG_DATA_W'($urandom_range(2, 6));
        default: val = CFG_DATA_W'($urandom_range(1, 64));
      endcase
      write_reg(CFG_SLOTS_PER_BLOCK, val);
      case ($urandom_range(0, 9))
        0:       val = 7'd1;
        1:       val = 7'd0;
        2:       val = 7'h7F;
        3:       val = 7'd16;
        4:       val = CFG_DATA_W'($urandom_range(17, 127));
        5, 6, 7: val = CFG_DATA_W'($urandom_range(2, 4));
        default: val = CFG_DATA_W'($urandom_range(1, 16));
      endcase
      write_reg(CFG_BLOCK_COUNT, val);
      // one phase runs flat out on both sides
      no_gaps = (phase == 3);
      for (int n = 0; n < 95; n++) begin
        // sender holds off once per phase, before item n == 40, until the block has caught up
        if (n == 40) drain();
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          send_item(make_op(MODE_ALLOC, $urandom_range(0, 15), $urandom_range(0, 63)));
        end else if (pick < 85 && held_q.size() != 0) begin
          idx = $urandom_range(0, held_q.size() - 1);
          h = held_q[idx];
          held_q.delete(idx);
          send_item(make_op(MODE_FREE, h.blk, h.slot));
        end else if (pick < 94) begin
          send_item(make_op(MODE_FREE, $urandom_range(0, 15), $urandom_range(0, 63)));
        end else if (pick < 97) begin
          send_item(make_op(MODE_CLEAR, $urandom_range(0, 15), $urandom_range(0, 63)));
        end else begin
          send_item(make_op(MODE_NOP, $urandom_range(0, 15), $urandom_range(0, 63)));
        end
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    refill_pool();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_single_slot_pool();
    test_register_change();
    test_random();
    drain();
    repeat (10) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      mismatches++;
    end
    $display("Run: %0d beats in, %0d results checked, %0d register writes.",
             items_sent, results_seen, reg_writes);
    $display("Allocations %0d, pool-full %0d, frees %0d, rejected frees %0d.",
             n_alloc_ok, n_full, n_free_ok, n_bad_free);
    if (mismatches == 0) begin
      $display("blocked_slot_allocator_tb passed");
    end else begin
      $display("blocked_slot_allocator_tb failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("blocked_slot_allocator_tb failed");
    $finish;
  end

endmodule
